[src/wbps_pkg.sv]
// Shared types and constants for the wildcard byte pattern scanner.
`timescale 1ns / 1ps
package wbps_pkg;

   localparam int DATA_W     = 8;
   localparam int LEN_W      = 5;
   localparam int PAT_BYTES  = 16;
   localparam int PAT_IDX_W  = 4;
   localparam int CNT_W      = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 64;

   // Register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] CSR_PAT_LO = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAT_HI = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CARE   = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LEN    = 2'd3;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef logic [PAT_BYTES-1:0][DATA_W-1:0] pattern_type;

   // Window status handed from the cell chain to the control logic
   typedef struct packed {
      logic hit;   // every in-use cell agrees with its pattern byte or is a wildcard
      logic full;  // window holds at least one pattern length of region bytes
   } match_type;

endpackage

[src/wbps_cell.sv]
// One window cell: holds a byte and its valid flag, compares the incoming byte.
`timescale 1ns / 1ps
module wbps_cell
   import wbps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  logic              clear,
   input  logic [DATA_W-1:0] din,
   input  logic              din_valid,
   input  logic [DATA_W-1:0] pat_byte,
   input  logic              care,
   input  logic              in_use,
   output logic [DATA_W-1:0] dout,
   output logic              dout_valid,
   output logic              hit
);

   logic [DATA_W-1:0] byte_ff;
   logic [DATA_W-1:0] byte_in;
   logic              valid_ff;
   logic              valid_in;

   // Compare the byte that lands here on this shift
   assign hit = !in_use || !care || (din == pat_byte);

   always_comb begin
      byte_in  = shift_en ? din : byte_ff;
      valid_in = valid_ff;
      if (clear) begin
         valid_in = 1'b0;
      end else if (shift_en) begin
         valid_in = din_valid;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign dout       = byte_ff;
   assign dout_valid = valid_ff;

endmodule

[src/wbps_chain.sv]
// Row of window cells with pattern alignment and match reduction.
`timescale 1ns / 1ps
module wbps_chain
   import wbps_pkg::*;
#(
   parameter int MAX_PATTERN = 16
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  logic                 clear,
   input  logic [DATA_W-1:0]    data_byte,
   input  pattern_type          pattern,
   input  logic [PAT_BYTES-1:0] care_mask,
   input  logic [LEN_W-1:0]     len,
   output match_type            status
);

   localparam int CELL_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [DATA_W-1:0]      cell_din   [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] cell_din_valid;
   logic [DATA_W-1:0]      cell_dout  [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] cell_dout_valid;
   logic [MAX_PATTERN-1:0] cell_hit;
   logic [LEN_W-1:0]       len_m1;

   assign len_m1 = len - LEN_W'(1);

   genvar j;
   generate
      for (j = 0; j < MAX_PATTERN; j++) begin : g_cell
         localparam logic [LEN_W-1:0] J = LEN_W'(j);
         logic             in_use;
         logic [LEN_W-1:0] pat_idx;

         // Cell j holds the byte that meets pattern byte len-1-j
         assign in_use  = (J < len);
         assign pat_idx = len_m1 - J;

         if (j == 0) begin : g_head
            assign cell_din[j]       = data_byte;
            assign cell_din_valid[j] = 1'b1;
         end else begin : g_link
            assign cell_din[j]       = cell_dout[j-1];
            assign cell_din_valid[j] = cell_dout_valid[j-1];
         end

         wbps_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift_en   (shift_en),
            .clear      (clear),
            .din        (cell_din[j]),
            .din_valid  (cell_din_valid[j]),
            .pat_byte   (pattern[pat_idx[PAT_IDX_W-1:0]]),
            .care       (care_mask[pat_idx[PAT_IDX_W-1:0]]),
            .in_use     (in_use),
            .dout       (cell_dout[j]),
            .dout_valid (cell_dout_valid[j]),
            .hit        (cell_hit[j])
         );
      end
   endgenerate

   assign status.hit  = &cell_hit;
   assign status.full = cell_din_valid[len_m1[CELL_IDX_W-1:0]];

endmodule

[src/wildcard_byte_pattern_scan_top.sv]
// Top level of the wildcard byte pattern scanner.
//
//  channel | direction | handshake             | payload
//  req_    | in        | req_tvalid/req_tready | tdata: data_byte, tlast: last_byte
//  rsp_    | out       | rsp_tvalid/rsp_tready | tdata: match_offset, tuser: found
//  csr_    | in        | csr_we                | csr_addr: register, csr_wdata: value
//
// One byte word is taken per cycle; the window compare is done across all
// cells in the cycle a byte arrives, so throughput is one word per clock.
// A result is registered and shows on rsp_ in the cycle after its word.
// The single output register is refilled in the cycle it drains, so
// req_tready drops only while a result waits and rsp_tready is low.
// Synchronous reset clears the region state and loads the register defaults.
`timescale 1ns / 1ps
module wildcard_byte_pattern_scan_top
   import wbps_pkg::*;
#(
   parameter int MAX_PATTERN = 16
)(
   input  logic                  clock,
   input  logic                  reset,
   // byte stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,
   // result
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // [31:0] match_offset
   output logic                  rsp_tuser,   // [0] found
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   pattern_type          pattern_ff;
   pattern_type          pattern_in;
   logic [PAT_BYTES-1:0] care_ff;
   logic [PAT_BYTES-1:0] care_in;
   logic [LEN_W-1:0]     length_ff;
   logic [LEN_W-1:0]     length_in;

   // Region state
   logic [CNT_W-1:0]     seen_ff;
   logic [CNT_W-1:0]     seen_in;
   logic                 done_ff;
   logic                 done_in;

   // Output register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 rsp_found_ff;
   logic                 rsp_found_in;
   logic [CNT_W-1:0]     rsp_offset_ff;
   logic [CNT_W-1:0]     rsp_offset_in;

   logic                 accept;
   logic                 region_end;
   logic [LEN_W-1:0]     len_eff;
   logic [CNT_W-1:0]     seen_next;
   logic                 hit_now;
   logic                 miss_now;
   logic                 rsp_load;
   match_type            status;

   // Take a word whenever the output register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign region_end = accept && req_tlast;

   // Clamp the pattern length to 1..MAX_PATTERN
   always_comb begin
      len_eff = length_ff;
      if (length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (length_ff > LEN_W'(MAX_PATTERN)) begin
         len_eff = LEN_W'(MAX_PATTERN);
      end
   end

   // Configuration writes
   always_comb begin
      pattern_in = pattern_ff;
      care_in    = care_ff;
      length_in  = length_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_PAT_LO: begin
               pattern_in[7:0] = csr_wdata;
            end
            CSR_PAT_HI: begin
               pattern_in[15:8] = csr_wdata;
            end
            CSR_CARE: begin
               care_in = csr_wdata[PAT_BYTES-1:0];
            end
            CSR_LEN: begin
               length_in = csr_wdata[LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         care_ff    <= '1;
         length_ff  <= LEN_W'(PAT_BYTES);
      end else begin
         pattern_ff <= pattern_in;
         care_ff    <= care_in;
         length_ff  <= length_in;
      end
   end

   wbps_chain #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (accept),
      .clear     (region_end),
      .data_byte (req_tdata),
      .pattern   (pattern_ff),
      .care_mask (care_ff),
      .len       (len_eff),
      .status    (status)
   );

   // Byte count including the incoming word; hold at the top value
   assign seen_next = (seen_ff == CNT_MAX) ? seen_ff : seen_ff + CNT_W'(1);

   // First match in the region, or a miss report on the final word
   assign hit_now  = !done_ff && status.full && status.hit;
   assign miss_now = req_tlast && !done_ff && !hit_now;
   assign rsp_load = accept && (hit_now || miss_now);

   always_comb begin
      seen_in = seen_ff;
      done_in = done_ff;
      if (region_end) begin
         seen_in = '0;
         done_in = 1'b0;
      end else if (accept) begin
         seen_in = seen_next;
         done_in = done_ff || hit_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         done_ff <= done_in;
      end
   end

   // Load a new result, drop the old one once taken, else hold
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_offset_in = rsp_offset_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = hit_now;
         rsp_offset_in = hit_now ? (seen_next - CNT_W'(len_eff)) : '0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = rsp_offset_ff;

   // A miss report always carries a zero offset
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_offset_ff == '0)
      else $error("miss result with nonzero offset");

   // No second result once a match was reported in the region
   a_one_match: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !done_ff)
      else $error("result after match in same region");

   // End of region returns the counters to zero
   a_region_clear: assert property (@(posedge clock) disable iff (reset)
      region_end |=> seen_ff == '0 && !done_ff)
      else $error("region state not cleared");

   // A match needs a window filled with region bytes
   a_hit_full: assert property (@(posedge clock) disable iff (reset)
      rsp_load && hit_now |-> seen_next >= CNT_W'(len_eff))
      else $error("match on a short window");

   // Reset leaves no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && seen_ff == '0)
      else $error("state not clear after reset");

endmodule

[test/testbench.sv]
// Testbench for the wildcard byte pattern scanner: directed table, then random regions.
`timescale 1ns / 1ps
module testbench
   import wbps_pkg::*;
();

   localparam int STALL_LIMIT   = 3000;  // cycles with no handshake at all
   localparam int REPORT_LIMIT  = 10;
   localparam int RANDOM_WORDS  = 400;
   localparam int PHASE_WORDS   = 50;
   localparam int SETTLE_CYCLES = 4;     // extra margin after the last result
   localparam int LONG_HOLD     = 200;
   localparam int MAX_REGION    = 48;
   localparam int DIRECTED_ROWS = 25;

   typedef enum logic {ROW_CSR, ROW_WORD} row_kind_type;

   typedef struct packed {
      logic        found;
      logic [31:0] offset;
   } scan_report_type;

   // One directed step: either a register write or a byte word. A word row
   // with known set carries the report it must produce, typed in by hand.
   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] value;
      logic [7:0]            data;
      logic                  last;
      logic                  known;
      scan_report_type       report;
   } plan_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = CSR_PAT_LO;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Hand-typed expectation that travels alongside the word on req_
   logic            word_known  = 1'b0;
   scan_report_type word_report = '0;

   // Shadow of the scanner: registers and region state
   logic [63:0]                       pat_lo_q = '0;
   logic [63:0]                       pat_hi_q = '0;
   logic [15:0]                       care_q   = 16'hFFFF;
   logic [4:0]                        len_q    = 5'd16;
   logic [PAT_BYTES-1:0][DATA_W-1:0]  window_q = '0;   // [0] holds the newest byte
   logic [CNT_W-1:0]                  seen_q   = '0;
   logic                              done_q   = 1'b0;

   scan_report_type awaited_reports[$];
   int              fault_count       = 0;
   int              quiet_cycles      = 0;

   // Knobs shared between the sender and the receiver
   bit quiet_sender    = 1'b0;
   bit steady_receiver = 1'b0;
   int hold_request    = 0;

   plan_row_type directed_plan [DIRECTED_ROWS] = '{
      // reset defaults: 16-byte pattern, so a one-byte region ends not found
      '{ROW_WORD, CSR_PAT_LO, '0, 8'h00, 1'b1, 1'b1, '{1'b0, 32'd0}},
      // length zero acts as one; a match on the final byte gives one report only
      '{ROW_CSR,  CSR_LEN,    64'h0,                  8'h00, 1'b0, 1'b0, '0},
      '{ROW_CSR,  CSR_PAT_LO, 64'h0000_0000_0000_00FF, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PAT_LO, '0, 8'hFF, 1'b1, 1'b1, '{1'b1, 32'd0}},
      // later bytes and the final byte of a matched region stay silent
      '{ROW_WORD, CSR_PAT_LO, '0, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PAT_LO, '0, 8'hFF, 1'b0, 1'b1, '{1'b1, 32'd1}},
      '{ROW_WORD, CSR_PAT_LO, '0, 8'hFF, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PAT_LO, '0, 8'h00, 1'b1, 1'b0, '0},
      // three bytes 12 ?? 56; mask and pattern bits past the length are junk
      '{ROW_CSR,  CSR_LEN,    64'hFFFF_0000_0000_0003, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_CSR,  CSR_CARE,   64'hA5A5_0000_0000_FFFD, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_CSR,  CSR_PAT_LO, 64'hFFFF_FFFF_FF56_A512, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PAT_LO, '0, 8'h12, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PAT_LO, '0, 8'h34, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PAT_LO, '0, 8'h12, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PAT_LO, '0, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PAT_LO, '0, 8'h56, 1'b0, 1'b1, '{1'b1, 32'd2}},
      '{ROW_WORD, CSR_PAT_LO, '0, 8'h56, 1'b1, 1'b0, '0},
      // region shorter than the pattern
      '{ROW_WORD, CSR_PAT_LO, '0, 8'hAA, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PAT_LO, '0, 8'h56, 1'b1, 1'b1, '{1'b0, 32'd0}},
      // all wildcards over two bytes
      '{ROW_CSR,  CSR_LEN,    64'h0000_0000_0000_0002, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_CSR,  CSR_CARE,   64'h0,                  8'h00, 1'b0, 1'b0, '0},
      '{ROW_CSR,  CSR_PAT_HI, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PAT_LO, '0, 8'h7E, 1'b1, 1'b1, '{1'b0, 32'd0}},
      '{ROW_WORD, CSR_PAT_LO, '0, 8'h7E, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PAT_LO, '0, 8'h81, 1'b1, 1'b1, '{1'b1, 32'd0}}
   };

   wildcard_byte_pattern_scan_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Pattern length as the scanner uses it: zero counts as one, clip at the window
   function automatic int used_length();
      int n;
      n = int'(len_q);
      if (n < 1) n = 1;
      if (n > PAT_BYTES) n = PAT_BYTES;
      return n;
   endfunction

   function automatic logic [7:0] pattern_at(input int k);
      logic [127:0] pat;
      pat = {pat_hi_q, pat_lo_q};
      return pat[8*k +: 8];
   endfunction

   // Shift one byte into the shadow window; return 1 when it yields a report
   function automatic bit scan_next_byte(input logic [7:0] b, input logic lst,
                                         output scan_report_type rpt);
      int n;
      int k;
      bit hit;
      bit emit;
      n    = used_length();
      emit = 1'b0;
      rpt  = '0;
      window_q = {window_q[PAT_BYTES-2:0], b};
      if (seen_q != CNT_MAX) seen_q = seen_q + 1;
      hit = !done_q && (seen_q >= n);
      for (k = 0; k < n; k++) begin
         if (care_q[k] && window_q[n-1-k] != pattern_at(k)) hit = 1'b0;
      end
      if (hit) begin
         done_q     = 1'b1;
         rpt.found  = 1'b1;
         rpt.offset = seen_q - n;
         emit       = 1'b1;
      end
      if (lst) begin
         if (!done_q) begin
            rpt  = '0;
            emit = 1'b1;
         end
         window_q = '0;
         seen_q   = '0;
         done_q   = 1'b0;
      end
      return emit;
   endfunction

   // Mostly back to back, sometimes a short pause, rarely a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99, 0);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   task automatic note_fault(input string what, input scan_report_type want,
                             input scan_report_type got);
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
         $display("%0t: %s: expected found=%0b offset=%0d, got found=%0b offset=%0d",
                  $time, what, want.found, want.offset, got.found, got.offset);
   endtask

   // Check results and predict new ones from the pre-edge handshake values.
   // Drain rsp_ first so a word accepted on this edge never pairs with it.
   always @(posedge clock) begin : monitor
      scan_report_type got;
      scan_report_type want;
      scan_report_type fresh;
      bit              emit;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.found  = rsp_tuser;
            got.offset = rsp_tdata;
            if (awaited_reports.size() == 0) begin
               note_fault("result with nothing expected", '0, got);
            end else begin
               want = awaited_reports.pop_front();
               if (got.found !== want.found) note_fault("found differs", want, got);
               if (got.offset !== want.offset) note_fault("match_offset differs", want, got);
            end
         end
         if (req_tvalid && req_tready) begin
            emit = scan_next_byte(req_tdata, req_tlast, fresh);
            if (word_known) awaited_reports.insert(awaited_reports.size(), word_report);
            else if (emit) awaited_reports.insert(awaited_reports.size(), fresh);
         end
         // watchdog: any handshake counts as progress
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("wildcard_byte_pattern_scan_top: mismatch");
               $finish;
            end
         end
      end
   end

   // Receiver: random ready pattern, steady stretches, and a long hold on request
   initial begin : receiver
      int span;
      forever begin
         if (hold_request > 0) begin
            span         = hold_request;
            hold_request = 0;
            rsp_tready  <= 1'b0;
         end else if (steady_receiver) begin
            span        = 1;
            rsp_tready <= 1'b1;
         end else begin
            span        = pick_gap() + 1;
            rsp_tready <= ($urandom_range(2, 0) != 0);   // ready twice as often as not
         end
         repeat (span) @(posedge clock);
      end
   end

   // Offer one word and hold it until accepted, then optionally drop valid
   task automatic send_word(input logic [7:0] b, input logic lst, input logic known,
                            input scan_report_type rpt, input int gap);
      req_tvalid  <= 1'b1;
      req_tdata   <= b;
      req_tlast   <= lst;
      word_known  <= known;
      word_report <= rpt;
      do @(posedge clock); while (!req_tready);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid, wait out every pending result, then let the pipeline drain
   task automatic settle();
      if (req_tvalid) req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register and mirror it; the caller lowers csr_we after a batch
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      case (addr)
         CSR_PAT_LO: pat_lo_q = value;
         CSR_PAT_HI: pat_hi_q = value;
         CSR_CARE:   care_q   = value[15:0];
         CSR_LEN:    len_q    = value[4:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   initial begin : stimulus
      int                    phase;
      int                    phase_words;
      int                    words_sent;
      int                    rlen;
      int                    n;
      int                    pos;
      int                    r;
      int                    i;
      int                    k;
      logic [7:0]            region [MAX_REGION];
      logic [CSR_DATA_W-1:0] value;
      logic [4:0]            len_pick;
      logic [15:0]           care_pick;
      logic [63:0]           lo_pick;
      logic [63:0]           hi_pick;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed table: settle before each batch of register writes
      for (i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_plan[i].kind == ROW_CSR) begin
            if (!csr_we) settle();
            write_reg(directed_plan[i].addr, directed_plan[i].value);
         end else begin
            if (csr_we) csr_we <= 1'b0;
            send_word(directed_plan[i].data, directed_plan[i].last, directed_plan[i].known,
                      directed_plan[i].report, pick_gap());
         end
      end

      // Random phases: new settings each time, regions that mostly carry the pattern
      phase      = 0;
      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         settle();
         case (phase % 6)
            0:       len_pick = 5'd0;
            1:       len_pick = 5'd1;
            2:       len_pick = 5'd16;
            3:       len_pick = 5'd31;
            default: len_pick = ($urandom_range(3, 0) == 0) ? 5'($urandom_range(31, 0))
                                                             : 5'($urandom_range(8, 2));
         endcase
         case (phase % 6)
            2: begin
               lo_pick   = '1;
               hi_pick   = '1;
               care_pick = 16'hFFFF;
            end
            3: begin
               lo_pick   = '0;
               hi_pick   = '0;
               care_pick = 16'h0000;
            end
            default: begin
               lo_pick   = {$urandom, $urandom};
               hi_pick   = {$urandom, $urandom};
               care_pick = ($urandom_range(1, 0) == 0) ? 16'hFFFF : 16'($urandom);
            end
         endcase
         write_reg(CSR_PAT_LO, lo_pick);
         write_reg(CSR_PAT_HI, hi_pick);
         // junk in the unused upper bits must not matter
         value = {$urandom, $urandom};
         value[15:0] = care_pick;
         write_reg(CSR_CARE, value);
         value = {$urandom, $urandom};
         value[4:0] = len_pick;
         write_reg(CSR_LEN, value);
         csr_we <= 1'b0;

         // every third phase runs without gaps on either side
         quiet_sender    = (phase % 3 == 0);
         steady_receiver = (phase % 3 == 0);
         n               = used_length();
         phase_words     = 0;
         while (phase_words < PHASE_WORDS) begin
            r = $urandom_range(99, 0);
            if (r < 15)      rlen = $urandom_range(3, 1);
            else if (r < 60) rlen = $urandom_range(16, 4);
            else             rlen = $urandom_range(MAX_REGION, 17);
            // filler leans on pattern bytes so partial matches are common
            for (i = 0; i < rlen; i++) begin
               if ($urandom_range(1, 0) == 0) region[i] = pattern_at($urandom_range(n - 1, 0));
               else                           region[i] = 8'($urandom);
            end
            if (rlen >= n && $urandom_range(99, 0) < 70) begin
               pos = $urandom_range(rlen - n, 0);
               for (k = 0; k < n; k++) begin
                  region[pos + k] = care_q[k] ? pattern_at(k) : 8'($urandom);
               end
               // break the embedded copy now and then
               if ($urandom_range(3, 0) == 0) begin
                  k = $urandom_range(n - 1, 0);
                  region[pos + k] = region[pos + k] ^ (8'h01 << $urandom_range(7, 0));
               end
            end
            for (i = 0; i < rlen; i++) begin
               // stall the receiver long enough that the block backs up
               if (phase == 1 && phase_words == 12) hold_request = LONG_HOLD;
               send_word(region[i], i == rlen - 1, 1'b0, '0,
                         quiet_sender ? 0 : pick_gap());
               phase_words++;
            end
         end
         words_sent += phase_words;
         phase++;
      end

      settle();
      if (fault_count == 0)
         $display("wildcard_byte_pattern_scan_top: match");
      else
         $display("wildcard_byte_pattern_scan_top: mismatch");
      $finish;
   end

endmodule

[wildcard_byte_pattern_scan_top.f]
src/wbps_pkg.sv
src/wbps_cell.sv
src/wbps_chain.sv
src/wildcard_byte_pattern_scan_top.sv
test/testbench.sv
